[rtl/cvr_pkg.sv]
package cvr_pkg;

  localparam int unsigned VEL_W   = 16;
  localparam int unsigned SPEED_W = 14;
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned IDX_W   = 3;

  typedef logic signed [VEL_W-1:0]   vel_t;
  typedef logic        [SPEED_W-1:0] speed_t;
  typedef logic        [CMD_W-1:0]   cmd_t;
  typedef logic        [IDX_W-1:0]   cfg_idx_t;

  typedef struct packed {
    vel_t lin;
    vel_t ang;
  } goal_pair_t;

  // motion command codes
  localparam cmd_t CMD_STOP           = 4'd0;
  localparam cmd_t CMD_STRAIGHT       = 4'd1;
  localparam cmd_t CMD_LEFT           = 4'd2;
  localparam cmd_t CMD_RIGHT          = 4'd3;
  localparam cmd_t CMD_ARC_LEFT       = 4'd4;
  localparam cmd_t CMD_ARC_RIGHT      = 4'd5;
  localparam cmd_t CMD_REVERSE        = 4'd6;
  localparam cmd_t CMD_SLOW_ARC_LEFT  = 4'd7;
  localparam cmd_t CMD_SLOW_ARC_RIGHT = 4'd8;
  localparam cmd_t CMD_SLOW_STRAIGHT  = 4'd9;
  localparam cmd_t CMD_SLOW_LEFT      = 4'd10;
  localparam cmd_t CMD_SLOW_RIGHT     = 4'd11;

  // configuration register indexes
  localparam cfg_idx_t REG_MAP_LINEAR    = 3'd0;
  localparam cfg_idx_t REG_MAP_TURN      = 3'd1;
  localparam cfg_idx_t REG_NORMAL_LINEAR = 3'd2;
  localparam cfg_idx_t REG_NORMAL_TURN   = 3'd3;
  localparam cfg_idx_t REG_SLOW_LINEAR   = 3'd4;
  localparam cfg_idx_t REG_SLOW_TURN     = 3'd5;
  localparam cfg_idx_t REG_MAPPING_MODE  = 3'd6;

  // reset values of the speed registers
  localparam speed_t MAP_LINEAR_RST    = 14'd1229;
  localparam speed_t MAP_TURN_RST      = 14'd1638;
  localparam speed_t NORMAL_LINEAR_RST = 14'd2048;
  localparam speed_t NORMAL_TURN_RST   = 14'd3277;
  localparam speed_t SLOW_LINEAR_RST   = 14'd819;
  localparam speed_t SLOW_TURN_RST     = 14'd1638;

  function automatic vel_t pos_speed(input speed_t s);
    pos_speed = vel_t'({2'b00, s});
  endfunction

  function automatic vel_t neg_speed(input speed_t s);
    neg_speed = -vel_t'({2'b00, s});
  endfunction

  // (3 * s) >> 2
  function automatic vel_t three_quarters(input speed_t s);
    logic [SPEED_W+1:0] tri3;
    tri3 = {2'b00, s} + {1'b0, s, 1'b0};
    three_quarters = vel_t'({2'b00, tri3[SPEED_W+1:2]});
  endfunction

  // -(s >> 1)
  function automatic vel_t neg_half(input speed_t s);
    neg_half = -vel_t'({3'b000, s[SPEED_W-1:1]});
  endfunction

  function automatic goal_pair_t pick_goals(
    input cmd_t       code,
    input speed_t     base_lin,
    input speed_t     base_turn,
    input speed_t     slow_lin,
    input speed_t     slow_turn,
    input goal_pair_t keep
  );
    goal_pair_t g;
    g = keep;
    case (code)
      CMD_STOP: begin
        g.lin = '0; g.ang = '0;
      end
      CMD_STRAIGHT: begin
        g.lin = pos_speed(base_lin); g.ang = '0;
      end
      CMD_LEFT: begin
        g.lin = '0; g.ang = pos_speed(base_turn);
      end
      CMD_RIGHT: begin
        g.lin = '0; g.ang = neg_speed(base_turn);
      end
      CMD_ARC_LEFT: begin
        g.lin = three_quarters(base_lin); g.ang = pos_speed(base_turn);
      end
      CMD_ARC_RIGHT: begin
        g.lin = three_quarters(base_lin); g.ang = neg_speed(base_turn);
      end
      CMD_REVERSE: begin
        g.lin = neg_half(base_lin); g.ang = '0;
      end
      CMD_SLOW_ARC_LEFT: begin
        g.lin = three_quarters(slow_lin); g.ang = pos_speed(slow_turn);
      end
      CMD_SLOW_ARC_RIGHT: begin
        g.lin = three_quarters(slow_lin); g.ang = neg_speed(slow_turn);
      end
      CMD_SLOW_STRAIGHT: begin
        g.lin = pos_speed(slow_lin); g.ang = '0;
      end
      CMD_SLOW_LEFT: begin
        g.lin = '0; g.ang = pos_speed(slow_turn);
      end
      CMD_SLOW_RIGHT: begin
        g.lin = '0; g.ang = neg_speed(slow_turn);
      end
      default: begin
        g = keep;
      end
    endcase
    pick_goals = g;
  endfunction

endpackage

[rtl/command_velocity_ramp.sv]
// command_velocity_ramp: linear set-point ramp for a forward / turn velocity pair
//
// input stream: one transaction per control tick. tuser flags that a new
// motion command comes with the tick, tdata carries the command code. A
// command picks new targets from the speed table and restarts a ramp of
// RAMP_STEPS ticks; every tick, with or without a command, yields exactly
// one output transaction with the velocities after that tick (Q3.12) and a
// flag that is set while ramp ticks remain.
// throughput: one tick per clock cycle, sustained while the receiver does not stall. Latency: the result of a
// tick is offered on the output stream in the cycle after its input
// transaction; all the work (table pick, reciprocal multiply, add) sits
// between the ramp state and the output register.
// stall: the output register holds its result while the receiver stalls;
// the input side is ready whenever that register is empty or being taken,
// so a stall holds the input back one-for-one without losing a tick.
// reset: velocities, targets, increments and the step count clear to zero,
// speed registers take their default values, no output is pending.
// configuration: plain write port, for the user to write only while the block is idle; the block does not enforce it.
module command_velocity_ramp
  import cvr_pkg::*;
#(
  parameter int unsigned RAMP_STEPS = 20
) (
  input  logic           clk,
  input  logic           rst,
  // configuration write port
  input  logic           cfg_we,
  input  cfg_idx_t       cfg_index,
  input  speed_t         cfg_data,
  // tick input stream
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,  // [3:0] command, [7:4] zero
  input  logic           s_axis_tuser,  // [0] command_valid
  // velocity output stream
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [39:0]    m_axis_tdata   // [15:0] linear_velocity,
                                        // [31:16] angular_velocity,
                                        // [32] ramping, [39:33] zero
);

  localparam int unsigned STEP_W      = $clog2(RAMP_STEPS + 1);
  // truncating divide by RAMP_STEPS as multiply by a rounded-up reciprocal;
  // exact for magnitudes below 2**15 while RAMP_STEPS stays below 32
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS);
  localparam logic [STEP_W-1:0] STEPS_INIT = STEP_W'(RAMP_STEPS);
  localparam logic [STEP_W-1:0] STEP_ONE   = STEP_W'(1);

  // speed registers
  speed_t map_linear_speed;
  speed_t map_turn_speed;
  speed_t normal_linear_speed;
  speed_t normal_turn_speed;
  speed_t slow_linear_speed;
  speed_t slow_turn_speed;
  logic   mapping_mode;

  // ramp state
  goal_pair_t        now;
  goal_pair_t        goal;
  goal_pair_t        inc;
  logic [STEP_W-1:0] steps_left;

  goal_pair_t        now_next;
  goal_pair_t        goal_next;
  goal_pair_t        inc_next;
  logic [STEP_W-1:0] steps_left_next;

  goal_pair_t        goal_pick;
  goal_pair_t        goal_sel;
  goal_pair_t        inc_sel;
  logic [STEP_W-1:0] steps_sel;
  logic signed [VEL_W:0] lin_diff;
  logic signed [VEL_W:0] ang_diff;

  speed_t base_lin;
  speed_t base_turn;
  logic   in_take;
  logic   cmd_go;
  logic   ramping_next;

  // signed divide by RAMP_STEPS, truncating toward zero
  function automatic vel_t ramp_div(input logic signed [VEL_W:0] d);
    logic [VEL_W:0]           mag;
    logic [VEL_W+RECIP_W:0]   prod;
    vel_t                     q;
    mag  = d[VEL_W] ? $unsigned(-d) : $unsigned(d);
    prod = {{RECIP_W{1'b0}}, mag} * {{(VEL_W+1){1'b0}}, RECIP};
    q    = vel_t'(prod[RECIP_SHIFT +: VEL_W]);
    ramp_div = d[VEL_W] ? -q : q;
  endfunction

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cmd_go        = in_take && s_axis_tuser;

  assign base_lin  = mapping_mode ? map_linear_speed : normal_linear_speed;
  assign base_turn = mapping_mode ? map_turn_speed   : normal_turn_speed;

  always_comb begin
    goal_pick = pick_goals(cmd_t'(s_axis_tdata[CMD_W-1:0]), base_lin, base_turn,
                           slow_linear_speed, slow_turn_speed, goal);
    goal_sel  = cmd_go ? goal_pick : goal;
    // differences need one bit more than the velocities
    lin_diff  = {goal_sel.lin[VEL_W-1], goal_sel.lin} - {now.lin[VEL_W-1], now.lin};
    ang_diff  = {goal_sel.ang[VEL_W-1], goal_sel.ang} - {now.ang[VEL_W-1], now.ang};
    inc_sel   = inc;
    steps_sel = steps_left;
    if (cmd_go) begin
      inc_sel.lin = ramp_div(lin_diff);
      inc_sel.ang = ramp_div(ang_diff);
      steps_sel   = STEPS_INIT;
    end

    now_next        = now;
    steps_left_next = steps_sel;
    if (steps_sel != '0) begin
      // last step lands exactly on the target
      if (steps_sel == STEP_ONE) begin
        now_next = goal_sel;
      end else begin
        now_next.lin = now.lin + inc_sel.lin;
        now_next.ang = now.ang + inc_sel.ang;
      end
      steps_left_next = steps_sel - STEP_ONE;
    end
    goal_next    = goal_sel;
    inc_next     = inc_sel;
    ramping_next = (steps_left_next != '0);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_linear_speed    <= MAP_LINEAR_RST;
      map_turn_speed      <= MAP_TURN_RST;
      normal_linear_speed <= NORMAL_LINEAR_RST;
      normal_turn_speed   <= NORMAL_TURN_RST;
      slow_linear_speed   <= SLOW_LINEAR_RST;
      slow_turn_speed     <= SLOW_TURN_RST;
      mapping_mode        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_LINEAR:    map_linear_speed    <= cfg_data;
        REG_MAP_TURN:      map_turn_speed      <= cfg_data;
        REG_NORMAL_LINEAR: normal_linear_speed <= cfg_data;
        REG_NORMAL_TURN:   normal_turn_speed   <= cfg_data;
        REG_SLOW_LINEAR:   slow_linear_speed   <= cfg_data;
        REG_SLOW_TURN:     slow_turn_speed     <= cfg_data;
        REG_MAPPING_MODE:  mapping_mode        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // ramp state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      goal       <= '0;
      inc        <= '0;
      steps_left <= '0;
    end else if (in_take) begin
      now        <= now_next;
      goal       <= goal_next;
      inc        <= inc_next;
      steps_left <= steps_left_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      m_axis_tdata <= {7'b0, ramping_next, now_next.ang, now_next.lin};
    end
  end

endmodule

[verif/command_velocity_ramp_tb.sv]
`timescale 1ns / 1ps

module command_velocity_ramp_tb
  import cvr_pkg::*;
();

  // ramp length of the block, matches its default parameter
  localparam int RAMP_TICKS = 20;
  // random ticks per configuration phase
  localparam int TICKS_PER_PHASE = 80;
  // length of the long receiver hold-off
  localparam int HOLD_CYCLES = 60;

  // codes the speed table does not know, targets are kept
  localparam cmd_t CMD_UNUSED_12 = 4'd12;
  localparam cmd_t CMD_UNUSED_13 = 4'd13;
  localparam cmd_t CMD_UNUSED_14 = 4'd14;
  localparam cmd_t CMD_UNUSED_15 = 4'd15;
  // register index with no register behind it
  localparam cfg_idx_t REG_UNUSED = 3'd7;

  // one output transaction: velocities after a tick and the ramp flag
  typedef struct {
    vel_t lin;
    vel_t ang;
    logic ramping;
  } velocity_sample_t;

  // directed row: tick contents, plus a typed result where it is obvious
  typedef struct {
    logic             cmd_valid;
    cmd_t             cmd;
    logic             typed;
    velocity_sample_t sample;
  } directed_row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  cfg_idx_t       cfg_index = '0;
  speed_t         cfg_data = '0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [7:0]     s_axis_tdata = '0;  // [3:0] command, [7:4] zero
  logic           s_axis_tuser = 1'b0;  // [0] command_valid
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [39:0]    m_axis_tdata;  // [15:0] linear, [31:16] angular, [32] ramping

  // speed table copy, follows every register write
  speed_t map_lin_speed    = MAP_LINEAR_RST;
  speed_t map_turn_speed   = MAP_TURN_RST;
  speed_t normal_lin_speed = NORMAL_LINEAR_RST;
  speed_t normal_turn_speed = NORMAL_TURN_RST;
  speed_t slow_lin_speed   = SLOW_LINEAR_RST;
  speed_t slow_turn_speed  = SLOW_TURN_RST;
  logic   mapping_on       = 1'b0;

  // ramp state copy
  vel_t       lin_now = '0;
  vel_t       ang_now = '0;
  vel_t       lin_goal = '0;
  vel_t       ang_goal = '0;
  vel_t       lin_step = '0;
  vel_t       ang_step = '0;
  logic [4:0] ticks_left = '0;

  velocity_sample_t expected_samples[$];
  int failures = 0;

  // idling knobs, redrawn per transaction from 0 up to these
  int gap_max = 12;
  int stall_max = 12;
  // long hold-off request for the receiver
  logic hold_req = 1'b0;

  directed_row_t directed_rows [19] = '{
    // command field without the valid flag is ignored, nothing moves
    '{1'b0, CMD_UNUSED_15,      1'b1, '{16'sd0,   16'sd0, 1'b0}},
    // stop from standstill: ramp starts but has nothing to move
    '{1'b1, CMD_STOP,           1'b1, '{16'sd0,   16'sd0, 1'b1}},
    // unknown code keeps the zero targets and restarts the ramp
    '{1'b1, CMD_UNUSED_12,      1'b1, '{16'sd0,   16'sd0, 1'b1}},
    // straight at normal speed 2048: first step 2048/20 truncated
    '{1'b1, CMD_STRAIGHT,       1'b1, '{16'sd102, 16'sd0, 1'b1}},
    '{1'b1, CMD_LEFT,           1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_RIGHT,          1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_ARC_LEFT,       1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_ARC_RIGHT,      1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_REVERSE,        1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_SLOW_ARC_LEFT,  1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_SLOW_ARC_RIGHT, 1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_SLOW_STRAIGHT,  1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_SLOW_LEFT,      1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_SLOW_RIGHT,     1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_UNUSED_13,      1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_UNUSED_14,      1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b1, CMD_UNUSED_15,      1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b0, CMD_STOP,           1'b0, '{16'sd0,   16'sd0, 1'b0}},
    '{1'b0, CMD_SLOW_RIGHT,     1'b0, '{16'sd0,   16'sd0, 1'b0}}
  };

  command_velocity_ramp #(
    .RAMP_STEPS(RAMP_TICKS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // advance the ramp copy by one tick and return what the block should show
  function automatic velocity_sample_t step_ramp(logic cmd_valid, cmd_t cmd);
    int base_lin;
    int base_turn;
    int slow_lin;
    int slow_turn;
    velocity_sample_t s;
    base_lin  = mapping_on ? map_lin_speed : normal_lin_speed;
    base_turn = mapping_on ? map_turn_speed : normal_turn_speed;
    slow_lin  = slow_lin_speed;
    slow_turn = slow_turn_speed;
    if (cmd_valid) begin
      case (cmd)
        CMD_STOP: begin
          lin_goal = '0; ang_goal = '0;
        end
        CMD_STRAIGHT: begin
          lin_goal = vel_t'(base_lin); ang_goal = '0;
        end
        CMD_LEFT: begin
          lin_goal = '0; ang_goal = vel_t'(base_turn);
        end
        CMD_RIGHT: begin
          lin_goal = '0; ang_goal = vel_t'(-base_turn);
        end
        CMD_ARC_LEFT: begin
          lin_goal = vel_t'((3 * base_lin) >>> 2); ang_goal = vel_t'(base_turn);
        end
        CMD_ARC_RIGHT: begin
          lin_goal = vel_t'((3 * base_lin) >>> 2); ang_goal = vel_t'(-base_turn);
        end
        CMD_REVERSE: begin
          lin_goal = vel_t'(-(base_lin >>> 1)); ang_goal = '0;
        end
        CMD_SLOW_ARC_LEFT: begin
          lin_goal = vel_t'((3 * slow_lin) >>> 2); ang_goal = vel_t'(slow_turn);
        end
        CMD_SLOW_ARC_RIGHT: begin
          lin_goal = vel_t'((3 * slow_lin) >>> 2); ang_goal = vel_t'(-slow_turn);
        end
        CMD_SLOW_STRAIGHT: begin
          lin_goal = vel_t'(slow_lin); ang_goal = '0;
        end
        CMD_SLOW_LEFT: begin
          lin_goal = '0; ang_goal = vel_t'(slow_turn);
        end
        CMD_SLOW_RIGHT: begin
          lin_goal = '0; ang_goal = vel_t'(-slow_turn);
        end
        default: begin
        end
      endcase
      // restart the ramp, increments truncate toward zero
      ticks_left = 5'(RAMP_TICKS);
      lin_step = vel_t'((int'(lin_goal) - int'(lin_now)) / RAMP_TICKS);
      ang_step = vel_t'((int'(ang_goal) - int'(ang_now)) / RAMP_TICKS);
    end
    if (ticks_left != 0) begin
      if (ticks_left == 1) begin
        // last tick lands exactly on the targets
        lin_now = lin_goal;
        ang_now = ang_goal;
      end else begin
        lin_now = lin_now + lin_step;
        ang_now = ang_now + ang_step;
      end
      ticks_left = ticks_left - 1'b1;
    end
    s.lin = lin_now;
    s.ang = ang_now;
    s.ramping = (ticks_left != 0);
    return s;
  endfunction

  // one register write, the table copy follows at once
  task automatic write_reg(cfg_idx_t idx, speed_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_MAP_LINEAR:    map_lin_speed = value;
      REG_MAP_TURN:      map_turn_speed = value;
      REG_NORMAL_LINEAR: normal_lin_speed = value;
      REG_NORMAL_TURN:   normal_turn_speed = value;
      REG_SLOW_LINEAR:   slow_lin_speed = value;
      REG_SLOW_TURN:     slow_turn_speed = value;
      REG_MAPPING_MODE:  mapping_on = value[0];
      default: begin
      end
    endcase
  endtask

  // offer one tick, wait for its transaction, queue the expected velocities;
  // valid stays high across back-to-back ticks
  task automatic drive_tick(logic cmd_valid, cmd_t cmd, logic typed,
                            velocity_sample_t fixed);
    int gap;
    velocity_sample_t s;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd_valid;
    s_axis_tdata <= {4'b0000, cmd};
    do @(posedge clk); while (!s_axis_tready);
    s = step_ramp(cmd_valid, cmd);
    expected_samples.push_back(typed ? fixed : s);
  endtask

  // stop offering and let every queued tick come out
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // output side: check each transaction, then stall at random or hold off
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          failures++;
          $display("%0t: unexpected output transaction, lin %0d ang %0d ramping %0b",
                   $time, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                   m_axis_tdata[32]);
        end else begin
          velocity_sample_t want;
          want = expected_samples.pop_front();
          if (m_axis_tdata[15:0] !== want.lin) begin
            failures++;
            $display("%0t: linear_velocity expected %0d got %0d", $time, want.lin,
                     $signed(m_axis_tdata[15:0]));
          end
          if (m_axis_tdata[31:16] !== want.ang) begin
            failures++;
            $display("%0t: angular_velocity expected %0d got %0d", $time, want.ang,
                     $signed(m_axis_tdata[31:16]));
          end
          if (m_axis_tdata[32] !== want.ramping) begin
            failures++;
            $display("%0t: ramping expected %0b got %0b", $time, want.ramping,
                     m_axis_tdata[32]);
          end
        end
        stall_left = $urandom_range(0, stall_max);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    velocity_sample_t none;
    int produced;
    int coast;
    none = '{16'sd0, 16'sd0, 1'b0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks at the reset speed table
    foreach (directed_rows[i]) begin
      drive_tick(directed_rows[i].cmd_valid, directed_rows[i].cmd,
                 directed_rows[i].typed, directed_rows[i].sample);
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      // new speed table, only with nothing in flight
      case (phase)
        0: begin
          // every register at its top value, mapping speeds on
          for (int r = 0; r < 7; r++) write_reg(cfg_idx_t'(r), '1);
        end
        1: begin
          // everything zero, normal speeds
          for (int r = 0; r < 7; r++) write_reg(cfg_idx_t'(r), '0);
        end
        default: begin
          for (int r = 0; r < 7; r++) write_reg(cfg_idx_t'(r), speed_t'($urandom));
          if (phase == 2) write_reg(REG_UNUSED, speed_t'($urandom));
        end
      endcase
      cfg_we <= 1'b0;

      // idling mix: full rate, one side bursty, both bursty
      gap_max = (phase == 1 || phase == 2) ? 0 : 12;
      stall_max = (phase == 1 || phase == 4) ? 0 : 12;
      // sender keeps offering at full rate while the output is held off
      if (phase == 2) hold_req = 1'b1;

      // a command, then a random run of plain ticks so ramps both finish
      // and get cut short; the ignored command field is random meanwhile
      produced = 0;
      while (produced < TICKS_PER_PHASE) begin
        drive_tick(1'b1, cmd_t'($urandom_range(0, 15)), 1'b0, none);
        produced++;
        coast = $urandom_range(0, 24);
        repeat (coast) begin
          drive_tick(1'b0, cmd_t'($urandom_range(0, 15)), 1'b0, none);
          produced++;
        end
      end
      drain();
    end

    // any stray transaction after the last expected one is caught here
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
